// ===== design/mfat_pkg.sv =====
// Shared constants for the motor feedback angle tracker.
`timescale 1ns / 1ps
package mfat_pkg;

  // Encoder counts per turn; also the divisor of the serial divider
  localparam logic [12:0] ENC_MAX       = 13'd8191;
  localparam logic [12:0] ENC_HALF      = ENC_MAX / 2;

  localparam logic [24:0] DELTA_LIMIT   = 25'd11796480;
  localparam logic [24:0] ENC_LIMIT     = 25'd23592960;
  localparam logic [47:0] ACC_MAX       = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] ACC_MIN       = 48'h8000_0000_0000;

  // Config register indexes
  localparam logic [1:0] REG_INV_RATIO  = 2'd0;
  localparam logic [1:0] REG_SET_TEMP   = 2'd1;
  localparam logic [1:0] REG_CLEAR_TEMP = 2'd2;

  localparam logic [16:0] INV_RATIO_RST = 17'd65536;
  localparam logic [7:0]  SET_TEMP_RST  = 8'd125;
  localparam logic [7:0]  CLEAR_TEMP_RST = 8'd100;

  // Serial step counts (last step index)
  localparam logic [5:0] MUL_LAST       = 6'd16;
  localparam logic [5:0] DIV_LAST       = 6'd37;

endpackage

// ===== design/motor_feedback_angle_tracker_core.sv =====
// Motor feedback angle tracker: delta unwrap, serial scale and divide, multi-turn angle.
// Steps of a frame: 17 multiply steps, 38 divide steps for the delta, 38 for the
// encoder angle, then the finish step. A new frame is taken only in the idle state,
// so the core holds one frame at a time in the bit-serial shift-add multiplier and
// the one-bit-per-cycle restoring divider by 8191, which both angles share.
// The output register frees the input side as soon as the finish cycle has run.
// Reset (rst, synchronous): config to defaults, first frame pending, angle and flag zero.
`timescale 1ns / 1ps
module motor_feedback_angle_tracker_core import mfat_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [16:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [12:0]        encoder_count,
  input  logic signed [15:0] speed_raw,
  input  logic signed [15:0] current_raw,
  input  logic [7:0]         temperature,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [24:0] delta_angle_q16,
  output logic signed [47:0] total_angle_q16,
  output logic [24:0]        encoder_angle_q16,
  output logic signed [15:0] speed_out,
  output logic signed [18:0] current_q12,
  output logic [7:0]         temperature_out,
  output logic               overheat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV_D = 3'd2;
  localparam logic [2:0] S_DIV_E = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]  state;
  logic [5:0]  cnt;

  logic [16:0] inv_ratio;
  logic [7:0]  set_temp;
  logic [7:0]  clear_temp;

  logic [12:0] prev_count;
  logic        first_frame;
  logic [47:0] acc;
  logic        hot;

  // serial datapath
  logic [37:0] work;
  logic [12:0] rem;
  logic [20:0] mcand;
  logic [21:0] enc360;
  logic        neg;
  logic [24:0] delta_mag;
  logic [24:0] enc_q;
  logic signed [15:0] speed_hold;
  logic signed [15:0] current_hold;
  logic [7:0]  temp_hold;

  logic        out_free;
  logic        take;

  // capture logic
  logic signed [13:0] diff;
  logic signed [13:0] d_unwrap;
  logic signed [13:0] d_negated;
  logic [11:0]        d_mag;
  logic [20:0]        d360;
  logic [21:0]        c360;

  // step logic
  logic [21:0] mul_sum;
  logic [37:0] mul_work;
  logic [13:0] div_shift;
  logic        div_ge;
  logic [12:0] div_rem;
  logic [37:0] div_work;
  logic [25:0] q_round;

  // finish logic
  logic [24:0]        delta_sat;
  logic signed [24:0] delta_s;
  logic [48:0]        acc_sum;
  logic [47:0]        acc_next;
  logic [24:0]        enc_sat;
  logic signed [18:0] cur_ext;
  logic signed [18:0] cur5;
  logic               hot_next;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    diff = $signed({1'b0, encoder_count}) - $signed({1'b0, prev_count});
    if (first_frame) begin
      diff = 14'sd0;
    end
    if (diff > $signed({1'b0, ENC_HALF})) begin
      d_unwrap = diff - $signed({1'b0, ENC_MAX});
    end else if (diff < -$signed({1'b0, ENC_HALF})) begin
      d_unwrap = diff + $signed({1'b0, ENC_MAX});
    end else begin
      d_unwrap = diff;
    end
    d_negated = -d_unwrap;
    d_mag = d_unwrap[13] ? d_negated[11:0] : d_unwrap[11:0];
    // x * 360 = x*256 + x*64 + x*32 + x*8
    d360 = {1'b0, d_mag, 8'd0} + {3'd0, d_mag, 6'd0} + {4'd0, d_mag, 5'd0}
         + {6'd0, d_mag, 3'd0};
    c360 = {1'b0, encoder_count, 8'd0} + {3'd0, encoder_count, 6'd0}
         + {4'd0, encoder_count, 5'd0} + {6'd0, encoder_count, 3'd0};
  end

  always_comb begin
    // shift-add multiply: multiplier sits in the low bits and shifts out
    mul_sum  = {1'b0, work[37:17]} + (work[0] ? {1'b0, mcand} : 22'd0);
    mul_work = {mul_sum, work[16:1]};
    // restoring divide by ENC_MAX, quotient bits shift in at the bottom
    div_shift = {rem, work[37]};
    div_ge    = (div_shift >= {1'b0, ENC_MAX});
    div_rem   = div_ge ? 13'(div_shift - {1'b0, ENC_MAX}) : div_shift[12:0];
    div_work  = {work[36:0], div_ge};
    // round to nearest: remainder above half the divisor means bit 12 set
    q_round   = {1'b0, div_work[24:0]} + {25'd0, div_rem[12]};
  end

  always_comb begin
    delta_sat = (delta_mag > DELTA_LIMIT) ? DELTA_LIMIT : delta_mag;
    delta_s   = neg ? $signed(25'(-delta_sat)) : $signed(delta_sat);
    acc_sum   = {acc[47], acc} + {{24{delta_s[24]}}, delta_s};
    if (acc_sum[48] != acc_sum[47]) begin
      acc_next = acc_sum[48] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = acc_sum[47:0];
    end
    enc_sat  = (enc_q > ENC_LIMIT) ? ENC_LIMIT : enc_q;
    cur_ext  = {{3{current_hold[15]}}, current_hold};
    cur5     = (cur_ext <<< 2) + cur_ext;
    if (temp_hold >= set_temp) begin
      hot_next = 1'b1;
    end else if (temp_hold <= clear_temp) begin
      hot_next = 1'b0;
    end else begin
      hot_next = hot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_ratio  <= INV_RATIO_RST;
      set_temp   <= SET_TEMP_RST;
      clear_temp <= CLEAR_TEMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_INV_RATIO:  inv_ratio  <= cfg_wdata;
        REG_SET_TEMP:   set_temp   <= cfg_wdata[7:0];
        REG_CLEAR_TEMP: clear_temp <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // result valid: set by the finish cycle, cleared by the output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= 6'd0;
      prev_count  <= 13'd0;
      first_frame <= 1'b1;
      acc         <= 48'd0;
      hot         <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            prev_count   <= encoder_count;
            first_frame  <= 1'b0;
            neg          <= d_unwrap[13];
            mcand        <= d360;
            enc360       <= c360;
            work         <= {21'd0, inv_ratio};
            speed_hold   <= speed_raw;
            current_hold <= current_raw;
            temp_hold    <= temperature;
            cnt          <= 6'd0;
            state        <= S_MUL;
          end
        end
        S_MUL: begin
          work <= mul_work;
          if (cnt == MUL_LAST) begin
            rem   <= 13'd0;
            cnt   <= 6'd0;
            state <= S_DIV_D;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DIV_D: begin
          if (cnt == DIV_LAST) begin
            delta_mag <= q_round[24:0];
            work      <= {enc360, 16'd0};
            rem       <= 13'd0;
            cnt       <= 6'd0;
            state     <= S_DIV_E;
          end else begin
            work <= div_work;
            rem  <= div_rem;
            cnt  <= cnt + 6'd1;
          end
        end
        S_DIV_E: begin
          work <= div_work;
          rem  <= div_rem;
          if (cnt == DIV_LAST) begin
            enc_q <= q_round[24:0];
            cnt   <= 6'd0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            acc               <= acc_next;
            hot               <= hot_next;
            delta_angle_q16   <= delta_s;
            total_angle_q16   <= $signed(acc_next);
            encoder_angle_q16 <= enc_sat;
            speed_out         <= speed_hold;
            current_q12       <= cur5;
            temperature_out   <= temp_hold;
            overheat          <= hot_next;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DIV_LAST)
    else $error("step counter past last divide step");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_D || state == S_DIV_E) |-> rem < ENC_MAX)
    else $error("divider remainder not reduced");

  a_delta_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (delta_angle_q16 <= $signed({1'b0, DELTA_LIMIT[23:0]})
                && delta_angle_q16 >= -$signed({1'b0, DELTA_LIMIT[23:0]})))
    else $error("delta angle outside 180 degrees");

  a_enc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> encoder_angle_q16 <= ENC_LIMIT)
    else $error("encoder angle above 360 degrees");

  a_start: assert property (@(posedge clk) disable iff (rst)
    take |=> (state == S_MUL && cnt == 6'd0 && !first_frame))
    else $error("frame transfer did not start the multiplier");

endmodule
